[hdl/sarm_pkg.sv]
// Shared types, constants and pose tables for the servo arm jog and pose ramp unit.
package sarm_pkg;

    // Angle limits and joint count
    localparam int unsigned NUM_JOINTS = 4;
    localparam logic [7:0]  MAX_ANGLE  = 8'd180;

    // Joint positions inside a pose vector
    localparam int unsigned J_BASE     = 0;
    localparam int unsigned J_SHOULDER = 1;
    localparam int unsigned J_ELBOW    = 2;
    localparam int unsigned J_WRIST    = 3;

    // Register map, index = paddr[4:2]
    typedef enum logic [2:0] {
        REG_STEP_SIZE     = 3'd0,
        REG_HOME_BASE     = 3'd1,
        REG_HOME_SHOULDER = 3'd2,
        REG_HOME_ELBOW    = 3'd3,
        REG_HOME_WRIST    = 3'd4
    } t_reg_idx;

    // Result status codes
    typedef enum logic [1:0] {
        ST_TICK    = 2'd0,
        ST_APPLIED = 2'd1,
        ST_UNKNOWN = 2'd2,
        ST_BUSY    = 2'd3
    } t_status;

    // Command characters (upper case)
    localparam logic [7:0] CMD_BASE_UP   = 8'h4C; // L
    localparam logic [7:0] CMD_BASE_DN   = 8'h4F; // O
    localparam logic [7:0] CMD_SHLD_UP   = 8'h59; // Y
    localparam logic [7:0] CMD_SHLD_DN   = 8'h48; // H
    localparam logic [7:0] CMD_ELBW_UP   = 8'h4A; // J
    localparam logic [7:0] CMD_ELBW_DN   = 8'h55; // U
    localparam logic [7:0] CMD_WRST_UP   = 8'h4B; // K
    localparam logic [7:0] CMD_WRST_DN   = 8'h49; // I
    localparam logic [7:0] CMD_HOME      = 8'h4E; // N
    localparam logic [7:0] CMD_REPORT    = 8'h50; // P
    localparam logic [7:0] CMD_PRESET_LO = 8'h31; // 1
    localparam logic [7:0] CMD_PRESET_HI = 8'h36; // 6
    localparam logic [7:0] CHR_LOWER_A   = 8'h61;
    localparam logic [7:0] CHR_LOWER_Z   = 8'h7A;
    localparam logic [7:0] CASE_OFFSET   = 8'h20;

    // Reset values
    localparam logic [7:0] RST_STEP_SIZE = 8'd5;
    localparam logic [7:0] RST_HOME_BASE = 8'd65;
    localparam logic [7:0] RST_HOME_REST = 8'd90;

    typedef logic [NUM_JOINTS-1:0][7:0] t_pose;

    typedef struct packed {
        logic       func;
        logic [7:0] cmd_byte;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] base_angle;
        logic [7:0] shoulder_angle;
        logic [7:0] elbow_angle;
        logic [7:0] wrist_angle;
        logic       ramping;
        logic [1:0] status;
    } t_out_beat;

    typedef struct packed {
        logic [7:0] step_size;
        t_pose      home;
    } t_cfg;

    typedef struct packed {
        t_pose cur;
        t_pose tgt;
        logic  moving;
    } t_state;

    // Saturate an angle to MAX_ANGLE
    function automatic logic [7:0] lim(input logic [7:0] v);
        return (v > MAX_ANGLE) ? MAX_ANGLE : v;
    endfunction

    // Reset pose, home values already inside range
    function automatic t_pose reset_pose();
        t_pose p;
        p[J_BASE]     = RST_HOME_BASE;
        p[J_SHOULDER] = RST_HOME_REST;
        p[J_ELBOW]    = RST_HOME_REST;
        p[J_WRIST]    = RST_HOME_REST;
        return p;
    endfunction

    // Fixed preset poses, selected by the low bits of the digit '1'..'6'
    function automatic t_pose preset_pose(input logic [2:0] k);
        t_pose p;
        p[J_BASE] = 8'd65;
        case (k)
            3'd1: begin
                p[J_SHOULDER] = 8'd160; p[J_ELBOW] = 8'd150; p[J_WRIST] = 8'd160;
            end
            3'd2: begin
                p[J_SHOULDER] = 8'd0;   p[J_ELBOW] = 8'd100; p[J_WRIST] = 8'd50;
            end
            3'd3: begin
                p[J_SHOULDER] = 8'd20;  p[J_ELBOW] = 8'd180; p[J_WRIST] = 8'd90;
            end
            3'd4: begin
                p[J_SHOULDER] = 8'd90;  p[J_ELBOW] = 8'd90;  p[J_WRIST] = 8'd155;
            end
            3'd5: begin
                p[J_SHOULDER] = 8'd85;  p[J_ELBOW] = 8'd90;  p[J_WRIST] = 8'd120;
            end
            3'd6: begin
                p[J_SHOULDER] = 8'd180; p[J_ELBOW] = 8'd180; p[J_WRIST] = 8'd90;
            end
            default: begin
                p[J_SHOULDER] = 8'd0;   p[J_ELBOW] = 8'd0;   p[J_WRIST] = 8'd0;
            end
        endcase
        return p;
    endfunction

endpackage

[hdl/sarm_step.sv]
// Next-state and result logic for one command or tick beat.
module sarm_step (
    input  sarm_pkg::t_state    i_state,
    input  sarm_pkg::t_cfg      i_cfg,
    input  sarm_pkg::t_in_beat  i_beat,
    output sarm_pkg::t_state    o_state,
    output sarm_pkg::t_out_beat o_beat
);
    import sarm_pkg::*;

    logic [7:0] uc;
    logic       jog_en;
    logic       jog_up;
    logic [1:0] jog_j;
    logic       ramp_en;
    t_pose      ramp_src;
    t_pose      ramp_tgt;
    logic       ramp_diff;
    t_pose      tick_cur;
    logic       tick_diff;
    logic [7:0] jog_cur;
    logic [8:0] jog_sum;
    logic [7:0] jog_res;
    t_status    status;

    // Fold lower case letters onto upper case
    always_comb begin
        uc = i_beat.cmd_byte;
        if (i_beat.cmd_byte inside {[CHR_LOWER_A:CHR_LOWER_Z]}) begin
            uc = i_beat.cmd_byte - CASE_OFFSET;
        end
    end

    // Command decode
    always_comb begin
        jog_en   = 1'b0;
        jog_up   = 1'b0;
        jog_j    = 2'(J_BASE);
        ramp_en  = 1'b0;
        ramp_src = i_cfg.home;
        status   = ST_APPLIED;
        case (uc) inside
            CMD_BASE_UP: begin jog_en = 1'b1; jog_up = 1'b1; jog_j = 2'(J_BASE);     end
            CMD_BASE_DN: begin jog_en = 1'b1;                jog_j = 2'(J_BASE);     end
            CMD_SHLD_UP: begin jog_en = 1'b1; jog_up = 1'b1; jog_j = 2'(J_SHOULDER); end
            CMD_SHLD_DN: begin jog_en = 1'b1;                jog_j = 2'(J_SHOULDER); end
            CMD_ELBW_UP: begin jog_en = 1'b1; jog_up = 1'b1; jog_j = 2'(J_ELBOW);    end
            CMD_ELBW_DN: begin jog_en = 1'b1;                jog_j = 2'(J_ELBOW);    end
            CMD_WRST_UP: begin jog_en = 1'b1; jog_up = 1'b1; jog_j = 2'(J_WRIST);    end
            CMD_WRST_DN: begin jog_en = 1'b1;                jog_j = 2'(J_WRIST);    end
            CMD_HOME: begin
                ramp_en = 1'b1;
            end
            CMD_REPORT: begin
            end
            [CMD_PRESET_LO:CMD_PRESET_HI]: begin
                ramp_en  = 1'b1;
                ramp_src = preset_pose(uc[2:0]);
            end
            default: begin
                status = ST_UNKNOWN;
            end
        endcase
    end

    // Jog arithmetic with saturation at both ends
    always_comb begin
        jog_cur = i_state.cur[jog_j];
        jog_sum = {1'b0, jog_cur} + {1'b0, i_cfg.step_size};
        if (jog_up) begin
            jog_res = (jog_sum > {1'b0, MAX_ANGLE}) ? MAX_ANGLE : jog_sum[7:0];
        end else begin
            jog_res = (i_cfg.step_size >= jog_cur) ? 8'd0 : jog_cur - i_cfg.step_size;
        end
    end

    // New ramp target and whether it differs from the current pose
    always_comb begin
        ramp_diff = 1'b0;
        for (int j = 0; j < NUM_JOINTS; j++) begin
            ramp_tgt[j] = lim(ramp_src[j]);
            if (ramp_tgt[j] != i_state.cur[j]) begin
                ramp_diff = 1'b1;
            end
        end
    end

    // One degree per joint toward the target
    always_comb begin
        tick_diff = 1'b0;
        for (int j = 0; j < NUM_JOINTS; j++) begin
            tick_cur[j] = i_state.cur[j];
            if (i_state.cur[j] < i_state.tgt[j]) begin
                tick_cur[j] = i_state.cur[j] + 8'd1;
            end else if (i_state.cur[j] > i_state.tgt[j]) begin
                tick_cur[j] = i_state.cur[j] - 8'd1;
            end
            if (tick_cur[j] != i_state.tgt[j]) begin
                tick_diff = 1'b1;
            end
        end
    end

    // Pick the state update and build the result beat
    always_comb begin
        o_state       = i_state;
        o_beat.status = ST_TICK;
        if (i_beat.func) begin
            if (i_state.moving) begin
                o_state.cur    = tick_cur;
                o_state.moving = tick_diff;
            end
        end else if (i_state.moving) begin
            o_beat.status = ST_BUSY;
        end else begin
            o_beat.status = status;
            if (jog_en) begin
                o_state.cur[jog_j] = jog_res;
                o_state.tgt[jog_j] = jog_res;
            end else if (ramp_en) begin
                o_state.tgt    = ramp_tgt;
                o_state.moving = ramp_diff;
            end
        end
        o_beat.base_angle     = o_state.cur[J_BASE];
        o_beat.shoulder_angle = o_state.cur[J_SHOULDER];
        o_beat.elbow_angle    = o_state.cur[J_ELBOW];
        o_beat.wrist_angle    = o_state.cur[J_WRIST];
        o_beat.ramping        = o_state.moving;
    end

endmodule

[hdl/servo_arm_jog_and_pose_ramp_unit.sv]
// Top level of the servo arm jog and pose ramp unit: handshake, registers, state.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_data) carries one beat per item:
//   func 1 is a motion tick, func 0 a command byte (jog, home, preset, report).
//   Output channel (o_out_valid / i_out_stall / o_out_data) returns exactly one
//   beat per item with the four joint angles, the ramping flag and a status code.
//   The APB port holds step_size and the home pose; write it only while idle.
//   Path: an accepted item enters the input register, then the result register.
//   Throughput: one item per cycle while the receiver does not stall; the joint
//   state is updated in a single pass of logic between the two registers.
//   Receiver stall: the result register holds its beat; the input register still
//   takes one more item, then o_in_stall rises until the result is taken.
//   Reset (synchronous, active low): pipeline empties, joints and targets go to
//   65/90/90/90, step_size to 5, home pose to 65/90/90/90, ramping to 0.
module servo_arm_jog_and_pose_ramp_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  sarm_pkg::t_in_beat  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output sarm_pkg::t_out_beat o_out_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import sarm_pkg::*;

    t_cfg      r_cfg;
    t_state    r_state;
    t_state    n_state;
    t_in_beat  r_in;
    logic      r_in_vld;
    t_out_beat r_out;
    t_out_beat n_out;
    logic      r_out_vld;
    logic      in_acc;
    logic      adv;
    logic      cfg_wr;

    // Handshake: the input register moves on when the result slot is free
    assign adv         = r_in_vld && (!r_out_vld || !i_out_stall);
    assign o_in_stall  = r_in_vld && !adv;
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    // Configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.step_size           <= RST_STEP_SIZE;
            r_cfg.home                <= reset_pose();
        end else if (cfg_wr) begin
            case (paddr[4:2])
                REG_STEP_SIZE:     r_cfg.step_size           <= pwdata[7:0];
                REG_HOME_BASE:     r_cfg.home[J_BASE]        <= pwdata[7:0];
                REG_HOME_SHOULDER: r_cfg.home[J_SHOULDER]    <= pwdata[7:0];
                REG_HOME_ELBOW:    r_cfg.home[J_ELBOW]       <= pwdata[7:0];
                REG_HOME_WRIST:    r_cfg.home[J_WRIST]       <= pwdata[7:0];
                default: begin
                end
            endcase
        end
    end

    // Register read back
    always_comb begin
        prdata = 32'd0;
        case (paddr[4:2])
            REG_STEP_SIZE:     prdata = {24'd0, r_cfg.step_size};
            REG_HOME_BASE:     prdata = {24'd0, r_cfg.home[J_BASE]};
            REG_HOME_SHOULDER: prdata = {24'd0, r_cfg.home[J_SHOULDER]};
            REG_HOME_ELBOW:    prdata = {24'd0, r_cfg.home[J_ELBOW]};
            REG_HOME_WRIST:    prdata = {24'd0, r_cfg.home[J_WRIST]};
            default:           prdata = 32'd0;
        endcase
    end

    // Per-beat state update
    sarm_step u_step (
        .i_state (r_state),
        .i_cfg   (r_cfg),
        .i_beat  (r_in),
        .o_state (n_state),
        .o_beat  (n_out)
    );

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else begin
            r_in_vld <= in_acc || (r_in_vld && !adv);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in <= i_in_data;
        end
    end

    // Joint state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.cur    <= reset_pose();
            r_state.tgt    <= reset_pose();
            r_state.moving <= 1'b0;
            r_out_vld      <= 1'b0;
        end else begin
            if (adv) begin
                r_state <= n_state;
            end
            r_out_vld <= adv || (r_out_vld && i_out_stall);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= n_out;
        end
    end

endmodule

[hdl/sarm_checker.sv]
// Port-level checks for the servo arm jog and pose ramp unit, bound to the top level.
module sarm_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input sarm_pkg::t_out_beat o_out_data
);
    import sarm_pkg::*;

    // Result beat holds while the receiver stalls
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result beat changed under stall");

    // Reported angles never leave the allowed range
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.base_angle <= MAX_ANGLE
                     && o_out_data.shoulder_angle <= MAX_ANGLE
                     && o_out_data.elbow_angle <= MAX_ANGLE
                     && o_out_data.wrist_angle <= MAX_ANGLE)
        else $error("joint angle above limit");

    // A command is only dropped while a ramp runs, and that ramp goes on
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status == ST_BUSY |-> o_out_data.ramping)
        else $error("busy drop reported without a running ramp");

    // Unknown commands are only decoded while idle
    a_unknown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status == ST_UNKNOWN |-> !o_out_data.ramping)
        else $error("unknown command reported during a ramp");

    // Reset empties the result slot
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

endmodule

bind servo_arm_jog_and_pose_ramp_unit sarm_checker u_sarm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

[bench/tb_servo_arm_jog_and_pose_ramp_unit.sv]
// Self-checking bench for the servo arm unit: directed table, random commands and ticks.
module tb_servo_arm_jog_and_pose_ramp_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import sarm_pkg::*;

    localparam int WATCHDOG_LIMIT   = 4000;
    localparam int RANDOM_PER_PHASE = 196;
    localparam int NUM_PHASES       = 5;
    localparam int DRAIN_CYCLES     = 4;

    // Directed stimulus: fixed rows carry their expected beat, the rest use the predictor
    typedef struct packed {
        logic       func;
        logic [7:0] cmd;
        logic       fixed;
        t_out_beat  want;
    } t_dir_row;

    localparam t_out_beat NO_BEAT         = '0;
    localparam t_out_beat AT_REST_APPLIED = '{8'd65, 8'd90, 8'd90, 8'd90, 1'b0, ST_APPLIED};
    localparam t_out_beat AT_REST_UNKNOWN = '{8'd65, 8'd90, 8'd90, 8'd90, 1'b0, ST_UNKNOWN};
    localparam t_out_beat AT_REST_TICK    = '{8'd65, 8'd90, 8'd90, 8'd90, 1'b0, ST_TICK};

    localparam int NUM_DIR = 23;
    localparam t_dir_row DIR_ROWS [NUM_DIR] = '{
        '{1'b0, CMD_REPORT,                 1'b1, AT_REST_APPLIED},
        '{1'b0, 8'hFF,                      1'b1, AT_REST_UNKNOWN},
        '{1'b1, 8'h00,                      1'b1, AT_REST_TICK},
        '{1'b0, 8'h00,                      1'b1, AT_REST_UNKNOWN},
        '{1'b0, CMD_PRESET_LO - 8'd1,       1'b1, AT_REST_UNKNOWN},
        '{1'b0, CMD_PRESET_HI + 8'd1,       1'b1, AT_REST_UNKNOWN},
        '{1'b0, CHR_LOWER_Z,                1'b1, AT_REST_UNKNOWN},
        '{1'b1, 8'hFF,                      1'b1, AT_REST_TICK},
        // jog every joint up and back down, mixed case
        '{1'b0, CMD_BASE_UP | CASE_OFFSET,  1'b0, NO_BEAT},
        '{1'b0, CMD_BASE_DN,                1'b0, NO_BEAT},
        '{1'b0, CMD_SHLD_UP | CASE_OFFSET,  1'b0, NO_BEAT},
        '{1'b0, CMD_SHLD_DN,                1'b0, NO_BEAT},
        '{1'b0, CMD_ELBW_UP,                1'b0, NO_BEAT},
        '{1'b0, CMD_ELBW_DN | CASE_OFFSET,  1'b0, NO_BEAT},
        '{1'b0, CMD_WRST_UP,                1'b0, NO_BEAT},
        '{1'b0, CMD_WRST_DN | CASE_OFFSET,  1'b0, NO_BEAT},
        // home while already there: no ramp
        '{1'b0, CMD_HOME | CASE_OFFSET,     1'b1, AT_REST_APPLIED},
        '{1'b0, CMD_REPORT | CASE_OFFSET,   1'b1, AT_REST_APPLIED},
        // start a ramp, then commands get dropped
        '{1'b0, CMD_PRESET_HI,              1'b0, NO_BEAT},
        '{1'b0, CMD_PRESET_LO,              1'b0, NO_BEAT},
        '{1'b1, 8'h00,                      1'b0, NO_BEAT},
        '{1'b0, 8'h80,                      1'b0, NO_BEAT},
        '{1'b1, 8'h55,                      1'b0, NO_BEAT}
    };

    localparam logic [7:0] CMD_SET [16] = '{
        CMD_BASE_UP, CMD_BASE_DN, CMD_SHLD_UP, CMD_SHLD_DN,
        CMD_ELBW_UP, CMD_ELBW_DN, CMD_WRST_UP, CMD_WRST_DN,
        CMD_HOME, CMD_REPORT,
        CMD_PRESET_LO, CMD_PRESET_LO + 8'd1, CMD_PRESET_LO + 8'd2,
        CMD_PRESET_LO + 8'd3, CMD_PRESET_LO + 8'd4, CMD_PRESET_HI
    };

    // Preset poses, base / shoulder / elbow / wrist
    localparam logic [7:0] PRESET_DEG [6][4] = '{
        '{8'd65, 8'd160, 8'd150, 8'd160},
        '{8'd65, 8'd0,   8'd100, 8'd50},
        '{8'd65, 8'd20,  8'd180, 8'd90},
        '{8'd65, 8'd90,  8'd90,  8'd155},
        '{8'd65, 8'd85,  8'd90,  8'd120},
        '{8'd65, 8'd180, 8'd180, 8'd90}
    };

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        in_valid   = 1'b0;
    t_in_beat    in_data    = '0;
    logic        out_stall  = 1'b0;
    logic        psel       = 1'b0;
    logic        penable    = 1'b0;
    logic        pwrite     = 1'b0;
    logic [4:0]  paddr      = '0;
    logic [31:0] pwdata     = '0;
    logic        o_in_stall;
    logic        o_out_valid;
    t_out_beat   o_out_data;
    logic [31:0] prdata;
    logic        pready;

    // Predictor state
    t_pose      pose_cur;
    t_pose      pose_tgt;
    logic       ramp_on;
    logic [7:0] jog_step;
    t_pose      home_cfg;

    t_out_beat  arm_beats [$];
    int         err_count    = 0;
    int         quiet_cycles = 0;
    int         send_idle_pct = 0;
    int         stall_pct     = 0;

    servo_arm_jog_and_pose_ramp_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #4 i_clk = ~i_clk;

    // Jog one joint, saturating at 0 and MAX_ANGLE; target follows
    function automatic void jog_joint(int j, bit up);
        logic [8:0] sum;
        logic [7:0] c;
        c = pose_cur[j];
        if (up) begin
            sum = {1'b0, c} + {1'b0, jog_step};
            c = (sum > {1'b0, MAX_ANGLE}) ? MAX_ANGLE : sum[7:0];
        end else begin
            c = (jog_step >= c) ? 8'd0 : c - jog_step;
        end
        pose_cur[j] = c;
        pose_tgt[j] = c;
    endfunction

    // Load a saturated target pose; ramp only if it differs from where we are
    function automatic void aim_at(t_pose p);
        logic differ;
        differ = 1'b0;
        for (int j = 0; j < NUM_JOINTS; j++) begin
            pose_tgt[j] = (p[j] > MAX_ANGLE) ? MAX_ANGLE : p[j];
            if (pose_tgt[j] != pose_cur[j])
                differ = 1'b1;
        end
        ramp_on = differ;
    endfunction

    // Apply one beat to the arm state, return the beat the unit should send back
    function automatic t_out_beat advance_arm(t_in_beat b);
        t_out_beat  r;
        logic [7:0] c;
        logic       differ;
        t_pose      p;
        int         k;
        t_status    st;
        if (b.func) begin
            if (ramp_on) begin
                differ = 1'b0;
                for (int j = 0; j < NUM_JOINTS; j++) begin
                    if (pose_cur[j] < pose_tgt[j])
                        pose_cur[j] = pose_cur[j] + 8'd1;
                    else if (pose_cur[j] > pose_tgt[j])
                        pose_cur[j] = pose_cur[j] - 8'd1;
                    if (pose_cur[j] != pose_tgt[j])
                        differ = 1'b1;
                end
                ramp_on = differ;
            end
            st = ST_TICK;
        end else if (ramp_on) begin
            st = ST_BUSY;
        end else begin
            c = b.cmd_byte;
            if (c >= CHR_LOWER_A && c <= CHR_LOWER_Z)
                c = c - CASE_OFFSET;
            st = ST_APPLIED;
            case (c)
                CMD_BASE_UP: jog_joint(J_BASE, 1'b1);
                CMD_BASE_DN: jog_joint(J_BASE, 1'b0);
                CMD_SHLD_UP: jog_joint(J_SHOULDER, 1'b1);
                CMD_SHLD_DN: jog_joint(J_SHOULDER, 1'b0);
                CMD_ELBW_UP: jog_joint(J_ELBOW, 1'b1);
                CMD_ELBW_DN: jog_joint(J_ELBOW, 1'b0);
                CMD_WRST_UP: jog_joint(J_WRIST, 1'b1);
                CMD_WRST_DN: jog_joint(J_WRIST, 1'b0);
                CMD_HOME:    aim_at(home_cfg);
                CMD_REPORT:  ;
                default: begin
                    if (c >= CMD_PRESET_LO && c <= CMD_PRESET_HI) begin
                        k = int'(c - CMD_PRESET_LO);
                        for (int j = 0; j < NUM_JOINTS; j++)
                            p[j] = PRESET_DEG[k][j];
                        aim_at(p);
                    end else begin
                        st = ST_UNKNOWN;
                    end
                end
            endcase
        end
        r.base_angle     = pose_cur[J_BASE];
        r.shoulder_angle = pose_cur[J_SHOULDER];
        r.elbow_angle    = pose_cur[J_ELBOW];
        r.wrist_angle    = pose_cur[J_WRIST];
        r.ramping        = ramp_on;
        r.status         = st;
        return r;
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            err_count++;
        end
    endfunction

    // Offer one beat, with a random lead-in gap; predict once it is taken
    task automatic send_beat(t_in_beat b, logic fixed, t_out_beat want);
        int        gap;
        logic      taken;
        t_out_beat pred;
        gap = 0;
        while ($urandom_range(0, 99) < send_idle_pct)
            gap++;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= b;
        do begin
            @(negedge i_clk);
            taken = !o_in_stall;
            @(posedge i_clk);
        end while (!taken);
        pred = advance_arm(b);
        arm_beats.push_back(fixed ? want : pred);
    endtask

    // Stop sending and wait for every outstanding result
    task automatic settle();
        in_valid <= 1'b0;
        do
            @(posedge i_clk);
        while (arm_beats.size() != 0);
    endtask

    // APB write: setup, then access until pready; read back afterwards
    task automatic write_reg(t_reg_idx idx, logic [7:0] v);
        logic rdy;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {24'd0, v};
        @(posedge i_clk);
        penable <= 1'b1;
        do begin
            @(negedge i_clk);
            rdy = pready;
            @(posedge i_clk);
        end while (!rdy);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_STEP_SIZE)
            jog_step = v;
        else
            home_cfg[int'(idx) - int'(REG_HOME_BASE)] = v;
        @(posedge i_clk);
        check_field("prdata", {24'd0, v}, prdata);
    endtask

    // Mostly tick through ramps and send real commands when idle, some noise
    function automatic t_in_beat pick_beat();
        t_in_beat b;
        int       roll;
        int       pick;
        int       tick_pct;
        roll       = $urandom_range(0, 99);
        tick_pct   = ramp_on ? 85 : 25;
        b.cmd_byte = 8'($urandom_range(0, 255));
        b.func     = 1'b0;
        if (roll < tick_pct) begin
            b.func = 1'b1;
        end else if (roll < 92) begin
            pick = $urandom_range(0, 15);
            b.cmd_byte = CMD_SET[pick];
            if (pick < 10 && $urandom_range(0, 1) == 1)
                b.cmd_byte = b.cmd_byte | CASE_OFFSET;
        end
        return b;
    endfunction

    // Receiver back-pressure
    always @(posedge i_clk)
        out_stall <= ($urandom_range(0, 99) < stall_pct);

    // Result checker and no-progress watchdog, sampled mid-cycle
    always @(negedge i_clk) begin
        t_out_beat want;
        if (i_rst_n) begin
            if ((in_valid && !o_in_stall) || (o_out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end else if (o_out_valid && !out_stall) begin
                if (arm_beats.size() == 0) begin
                    $error("result beat with nothing pending");
                    err_count++;
                end else begin
                    want = arm_beats.pop_front();
                    check_field("base_angle", 32'(want.base_angle),
                                32'(o_out_data.base_angle));
                    check_field("shoulder_angle", 32'(want.shoulder_angle),
                                32'(o_out_data.shoulder_angle));
                    check_field("elbow_angle", 32'(want.elbow_angle),
                                32'(o_out_data.elbow_angle));
                    check_field("wrist_angle", 32'(want.wrist_angle),
                                32'(o_out_data.wrist_angle));
                    check_field("ramping", 32'(want.ramping), 32'(o_out_data.ramping));
                    check_field("status", 32'(want.status), 32'(o_out_data.status));
                end
            end
        end
    end

    initial begin
        t_in_beat b;
        logic [7:0] step_v;
        t_pose      home_v;

        // predictor reset state
        pose_cur = {RST_HOME_REST, RST_HOME_REST, RST_HOME_REST, RST_HOME_BASE};
        pose_tgt = pose_cur;
        home_cfg = pose_cur;
        jog_step = RST_STEP_SIZE;
        ramp_on  = 1'b0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            // idling profile: sender-light, then receiver-light, then none
            if (phase < 2) begin
                send_idle_pct = 8;
                stall_pct     = 74;
            end else if (phase < 4) begin
                send_idle_pct = 74;
                stall_pct     = 8;
            end else begin
                send_idle_pct = 0;
                stall_pct     = 0;
            end

            // new register setting while idle; extremes first, then random
            if (phase > 0) begin
                settle();
                case (phase)
                    1: begin step_v = 8'd180; home_v = {8'd0, 8'd0, 8'd0, 8'd0}; end
                    2: begin step_v = 8'd0;   home_v = {4{MAX_ANGLE}}; end
                    3: begin step_v = 8'd255; home_v = {8'd255, 8'd181, 8'd200, 8'd255}; end
                    default: begin
                        step_v = 8'($urandom_range(0, 255));
                        for (int j = 0; j < NUM_JOINTS; j++)
                            home_v[j] = 8'($urandom_range(0, 255));
                    end
                endcase
                write_reg(REG_STEP_SIZE, step_v);
                write_reg(REG_HOME_BASE, home_v[J_BASE]);
                write_reg(REG_HOME_SHOULDER, home_v[J_SHOULDER]);
                write_reg(REG_HOME_ELBOW, home_v[J_ELBOW]);
                write_reg(REG_HOME_WRIST, home_v[J_WRIST]);
            end

            if (phase == 0) begin
                for (int r = 0; r < NUM_DIR; r++) begin
                    b.func     = DIR_ROWS[r].func;
                    b.cmd_byte = DIR_ROWS[r].cmd;
                    send_beat(b, DIR_ROWS[r].fixed, DIR_ROWS[r].want);
                end
            end

            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                send_beat(pick_beat(), 1'b0, NO_BEAT);
                // hold off once mid-run until the pipeline is empty
                if (phase == 0 && n == RANDOM_PER_PHASE / 2)
                    settle();
            end
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_count == 0 && arm_beats.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
